[hdl/rce_pkg.sv]
// ----------------------------------------------------------------------------
// Rotary encoder package
// Shared types, constants and the quadrature step table for the rotary
// encoder with click detection.
// ----------------------------------------------------------------------------
package rce_pkg;

   // Width of the internal time arithmetic; differences wrap at this width.
   localparam int TIME_BITS = 32;

   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FAST_WINDOW = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FAST_MULT   = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHORT_LIMIT = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_LIMIT  = 8'd3;

   // Reset values of the configuration registers.
   localparam logic [15:0] FAST_WINDOW_RESET = 16'd80;
   localparam logic [3:0]  FAST_MULT_RESET   = 4'd5;
   localparam logic [15:0] SHORT_LIMIT_RESET = 16'd1200;
   localparam logic [15:0] LONG_LIMIT_RESET  = 16'd2000;

   typedef logic [TIME_BITS-1:0] time_type;

   typedef struct packed {
      logic        phase_a;
      logic        phase_b;
      logic        switch_level;
      logic [31:0] now_ms;
      logic        take_delta;
      logic        take_short;
      logic        take_long;
   } req_type;

   typedef struct packed {
      logic signed [7:0] delta;
      logic              short_click;
      logic              long_click;
   } rsp_type;

   typedef struct packed {
      logic [15:0] fast_window_ms;
      logic [3:0]  fast_multiplier;
      logic [15:0] short_limit_ms;
      logic [15:0] long_limit_ms;
   } cfg_type;

   // Quadrature step, indexed by old phase times four plus new phase.
   localparam logic signed [1:0] QUAD_STEPS [16] = '{
       2'sd0, -2'sd1,  2'sd1,  2'sd0,
       2'sd1,  2'sd0,  2'sd0, -2'sd1,
      -2'sd1,  2'sd0,  2'sd0,  2'sd1,
       2'sd0,  2'sd1, -2'sd1,  2'sd0
   };

endpackage

[hdl/rce_rotation.sv]
// ----------------------------------------------------------------------------
// Rotary encoder rotation tracker
// Decodes quadrature steps, applies acceleration and keeps the saturating
// rotation delta.
// ----------------------------------------------------------------------------
module rce_rotation (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [1:0]             phase,
   input  rce_pkg::time_type      now,
   input  logic                   take_delta,
   input  rce_pkg::cfg_type       cfg,
   output logic signed [7:0]      delta
);
   import rce_pkg::*;

   logic              primed_ff, primed_in;
   logic [1:0]        old_phase_ff, old_phase_in;
   logic signed [7:0] delta_ff, delta_in;
   time_type          last_ff, last_in;

   logic signed [1:0] step;
   logic              fast;
   logic signed [4:0] step_val;
   logic signed [9:0] sum;
   logic signed [7:0] delta_upd;
   time_type          elapsed;

   always_comb begin
      step      = QUAD_STEPS[{old_phase_ff, phase}];
      elapsed   = now - last_ff;
      fast      = elapsed < TIME_BITS'(cfg.fast_window_ms);
      // The decoded step is -1, 0 or +1 and is only used when nonzero, so the product is a selection.
      if (fast) begin
         step_val = (step < 0) ? -$signed({1'b0, cfg.fast_multiplier})
                               :  $signed({1'b0, cfg.fast_multiplier});
      end else begin
         step_val = 5'(step);
      end
      sum = 10'(delta_ff) + 10'(step_val);
      if (sum > 10'sd127) begin
         delta_upd = 8'sd127;
      end else if (sum < -10'sd128) begin
         delta_upd = -8'sd128;
      end else begin
         delta_upd = sum[7:0];
      end

      primed_in    = primed_ff;
      old_phase_in = old_phase_ff;
      last_in      = last_ff;
      delta        = delta_ff;
      if (!primed_ff) begin
         primed_in    = 1'b1;
         old_phase_in = phase;
      end else if (phase != old_phase_ff) begin
         old_phase_in = phase;
         if (step != 2'sd0) begin
            delta   = delta_upd;
            last_in = now;
         end
      end
      delta_in = take_delta ? 8'sd0 : delta;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff    <= 1'b0;
         old_phase_ff <= 2'b00;
         delta_ff     <= 8'sd0;
         last_ff      <= '0;
      end else if (fire) begin
         primed_ff    <= primed_in;
         old_phase_ff <= old_phase_in;
         delta_ff     <= delta_in;
         last_ff      <= last_in;
      end
   end

endmodule

[hdl/rce_button.sv]
// ----------------------------------------------------------------------------
// Rotary encoder button tracker
// Times presses of the push switch and raises the short and long click flags.
// ----------------------------------------------------------------------------
module rce_button (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic              pressed,
   input  rce_pkg::time_type now,
   input  logic              take_short,
   input  logic              take_long,
   input  rce_pkg::cfg_type  cfg,
   output logic              short_click,
   output logic              long_click
);
   import rce_pkg::*;

   logic     held_ff, held_in;
   time_type press_ff, press_in;
   logic     short_ff, short_in;
   logic     long_ff, long_in;
   logic     held_mid;
   time_type held_time;

   always_comb begin
      held_mid    = held_ff;
      press_in    = press_ff;
      short_click = short_ff;
      long_click  = long_ff;
      if (pressed && !held_ff) begin
         held_mid = 1'b1;
         press_in = now;
      end
      if (!pressed && held_ff) begin
         held_mid = 1'b0;
         if ((now - press_ff) < TIME_BITS'(cfg.short_limit_ms)) begin
            short_click = 1'b1;
         end
      end
      held_time = now - press_in;
      held_in   = held_mid;
      // A long hold reports once and re-arms, so a held switch starts anew.
      if (held_mid && held_time > TIME_BITS'(cfg.long_limit_ms)) begin
         long_click = 1'b1;
         held_in    = 1'b0;
      end
      short_in = take_short ? 1'b0 : short_click;
      long_in  = take_long ? 1'b0 : long_click;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         press_ff <= '0;
         short_ff <= 1'b0;
         long_ff  <= 1'b0;
      end else if (fire) begin
         held_ff  <= held_in;
         press_ff <= press_in;
         short_ff <= short_in;
         long_ff  <= long_in;
      end
   end

endmodule

[hdl/rotary_encoder_with_click_detect.sv]
// ----------------------------------------------------------------------------
// Rotary encoder with click detect
// Quadrature decoder with step acceleration and push-button short and long
// click detection, one result beat for every sample beat.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                            Direction  Beat carries
//   req      req_valid/req_ready/req_data     in         one pin sample
//   rsp      rsp_valid/rsp_ready/rsp_data     out        delta and click flags
//   csr      csr_valid/csr_ready/csr_index/   in         one register write
//            csr_data
//
// A sample beat is captured in the input register and processed in one pass of
// table lookup, subtractions, compares and one add; its result beat is captured in
// the result register and offered on rsp, and a new sample beat can be taken every cycle while rsp is not stalled.
// A stalled result beat holds the sample behind it in the input register, and
// req_ready stays low until the result beat is taken.
// Synchronous reset clears the valid flags and tracker state and restores register defaults; csr is always ready.
//
module rotary_encoder_with_click_detect (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  rce_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rce_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rce_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rce_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import rce_pkg::*;

   cfg_type cfg_ff;

   logic    in_valid_ff;
   req_type in_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic     advance;
   time_type now;

   // The sample in the input register is processed when the result register
   // is empty or its beat is being taken in this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign now       = TIME_BITS'(in_ff.now_ms);

   // Configuration registers. Writes beyond the last index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_window_ms  <= FAST_WINDOW_RESET;
         cfg_ff.fast_multiplier <= FAST_MULT_RESET;
         cfg_ff.short_limit_ms  <= SHORT_LIMIT_RESET;
         cfg_ff.long_limit_ms   <= LONG_LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FAST_WINDOW: cfg_ff.fast_window_ms  <= csr_data;
            CSR_FAST_MULT:   cfg_ff.fast_multiplier <= csr_data[3:0];
            CSR_SHORT_LIMIT: cfg_ff.short_limit_ms  <= csr_data;
            CSR_LONG_LIMIT:  cfg_ff.long_limit_ms   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   rce_rotation u_rotation (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .phase      ({in_ff.phase_a, in_ff.phase_b}),
      .now        (now),
      .take_delta (in_ff.take_delta),
      .cfg        (cfg_ff),
      .delta      (rsp_in.delta)
   );

   rce_button u_button (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .pressed     (!in_ff.switch_level),
      .now         (now),
      .take_short  (in_ff.take_short),
      .take_long   (in_ff.take_long),
      .cfg         (cfg_ff),
      .short_click (rsp_in.short_click),
      .long_click  (rsp_in.long_click)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef NO_ASSERTIONS
   // A processed sample always shows up as a result beat in the next cycle.
   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed sample did not reach the result register");

   // A held sample is never overwritten by a new beat.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> !req_ready)
      else $error("input register accepts while holding a stalled sample");

   // A pending result is only replaced once its beat has been taken.
   a_rsp_not_lost: assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_valid_ff) |-> rsp_ready)
      else $error("result register overwritten before its beat was taken");
`endif

endmodule

[tb/sv/rotary_encoder_with_click_detect_tb.sv]
// ----------------------------------------------------------------------------
// Rotary encoder with click detect testbench
// Streams pin samples into the decoder and scores every result beat against
// a cycle-free model of the quadrature, acceleration and button logic.
// A directed opening covers the corner cases. Random phases then follow
// under several register settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module rotary_encoder_with_click_detect_tb;
   import rce_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int          PHASE_SAMPLES  = 190;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data  = '0;

   rotary_encoder_with_click_detect u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 12 time unit period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Samples waiting to be offered, and the reports that accepted samples owe.
   req_type     sample_backlog[$];
   rsp_type     pending_reports[$];
   int unsigned samples_queued = 0;
   int unsigned samples_taken  = 0;
   int unsigned reports_seen   = 0;
   int unsigned fail_count     = 0;
   int unsigned quiet_cycles   = 0;

   // Model of the decoder: encoder and button state plus the register copies.
   logic        enc_primed;
   logic [1:0]  enc_phase;
   int          rotation;
   logic [31:0] last_step_ms;
   logic        button_down;
   logic [31:0] press_ms;
   logic        short_seen;
   logic        long_seen;
   logic [15:0] window_ms;
   logic [3:0]  multiplier;
   logic [15:0] short_ms;
   logic [15:0] long_ms;

   // Random stimulus walks a knob: position on the Gray cycle, direction of
   // spin, switch state and the millisecond clock carry over between samples.
   logic [1:0]  stim_pos     = 2'd3;
   logic [1:0]  stim_spin    = 2'd1;
   logic        stim_pressed = 1'b0;
   logic [31:0] stim_now     = '0;

   // Gap control shared by both channel processes. A burst forces a stretch
   // of back-to-back beats so that the no-idle case is exercised as well.
   function automatic int unsigned draw_wait(inout int unsigned burst);
      if (burst != 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         burst = $urandom_range(8, 40);
      end
      return $urandom_range(0, 5);
   endfunction

   // Applies one sample to the model and returns the report it produces.
   // The quadrature step comes from the position of each phase pair on the
   // Gray cycle 00, 01, 11, 10: one place forward is -1, one back is +1, and
   // a jump of two places is a glitch that moves nothing.
   function automatic rsp_type advance_encoder(req_type s);
      logic [1:0]  new_phase;
      logic [1:0]  turn;
      logic [31:0] elapsed;
      int          step;
      rsp_type     report;
      new_phase = {s.phase_a, s.phase_b};
      if (!enc_primed) begin
         // The first sample after reset only records where the knob sits.
         enc_primed = 1'b1;
         enc_phase  = new_phase;
      end else if (new_phase != enc_phase) begin
         turn = {new_phase[1], ^new_phase} - {enc_phase[1], ^enc_phase};
         step = (turn == 2'd1) ? -1 : (turn == 2'd3) ? 1 : 0;
         if (step != 0) begin
            // Time differences wrap at 32 bits. A multiplier of zero
            // swallows an accelerated step but the timestamp still moves.
            elapsed = s.now_ms - last_step_ms;
            if (elapsed < {16'd0, window_ms}) begin
               step = step * int'(multiplier);
            end
            rotation = rotation + step;
            if (rotation > 127) begin
               rotation = 127;
            end else if (rotation < -128) begin
               rotation = -128;
            end
            last_step_ms = s.now_ms;
         end
         enc_phase = new_phase;
      end

      // The switch is active low.
      if (!s.switch_level && !button_down) begin
         button_down = 1'b1;
         press_ms    = s.now_ms;
      end
      if (s.switch_level && button_down) begin
         button_down = 1'b0;
         elapsed     = s.now_ms - press_ms;
         if (elapsed < {16'd0, short_ms}) begin
            short_seen = 1'b1;
         end
      end
      // A hold past the long limit flags and re-arms, so a switch that is
      // still down starts a fresh press on the following sample.
      elapsed = s.now_ms - press_ms;
      if (button_down && elapsed > {16'd0, long_ms}) begin
         long_seen   = 1'b1;
         button_down = 1'b0;
      end

      report.delta       = 8'(rotation);
      report.short_click = short_seen;
      report.long_click  = long_seen;

      // The report shows the state before the take bits clear it.
      if (s.take_delta) begin
         rotation = 0;
      end
      if (s.take_short) begin
         short_seen = 1'b0;
      end
      if (s.take_long) begin
         long_seen = 1'b0;
      end
      return report;
   endfunction

   function automatic void queue_sample(input logic a, input logic b, input logic sw,
                                        input logic [31:0] at, input logic td,
                                        input logic ts, input logic tl);
      req_type s;
      s.phase_a      = a;
      s.phase_b      = b;
      s.switch_level = sw;
      s.now_ms       = at;
      s.take_delta   = td;
      s.take_short   = ts;
      s.take_long    = tl;
      sample_backlog.push_back(s);
      samples_queued++;
   endfunction

   // Mostly coherent rotation with a persistent direction, so the delta runs
   // into saturation, mixed with glitches, random jumps of the knob and of
   // the clock. Time steps are sized against the current long limit so
   // that short and long clicks both occur.
   task automatic queue_random_samples(input int count);
      int unsigned pick;
      logic [1:0]  phase;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            stim_now += $urandom_range(0, 100);
         end else if (pick < 85) begin
            stim_now += $urandom_range(0, int'(long_ms) + 300);
         end else if (pick < 97) begin
            stim_now += $urandom_range(0, 70000);
         end else begin
            stim_now = $urandom();
         end
         if ($urandom_range(0, 19) == 0) begin
            stim_spin = -stim_spin;
         end
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            stim_pos += stim_spin;
         end else if (pick == 8) begin
            stim_pos += 2'd2;
         end else if (pick == 9) begin
            stim_pos = 2'($urandom());
         end
         if ($urandom_range(0, 5) == 0) begin
            stim_pressed = !stim_pressed;
         end
         phase = {stim_pos[1], ^stim_pos};
         queue_sample(phase[1], phase[0], !stim_pressed, stim_now,
                      $urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0,
                      $urandom_range(0, 3) == 0);
      end
   endtask

   // One register write beat. The model copy changes once the beat is taken.
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_FAST_WINDOW: window_ms  = value;
         CSR_FAST_MULT:   multiplier = value[3:0];
         CSR_SHORT_LIMIT: short_ms   = value;
         CSR_LONG_LIMIT:  long_ms    = value;
         default: ;
      endcase
   endtask

   // Every sample yields a report, so the block is idle once all have come back.
   task automatic wait_for_drain();
      while (samples_taken != samples_queued || pending_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Reprograms all four registers, plus one write to an unused index, and
   // then runs a batch of random samples. The multiplier write carries
   // random upper bits, which the block must drop.
   task automatic run_phase(input logic [15:0] window, input logic [3:0] mult,
                            input logic [15:0] short_limit,
                            input logic [15:0] long_limit);
      wait_for_drain();
      write_register(CSR_FAST_WINDOW, window);
      write_register(CSR_FAST_MULT, {12'($urandom()), mult});
      write_register(CSR_SHORT_LIMIT, short_limit);
      write_register(CSR_LONG_LIMIT, long_limit);
      write_register(CSR_INDEX_BITS'($urandom_range(4, 255)), 16'($urandom()));
      queue_random_samples(PHASE_SAMPLES);
   endtask

   // Sample driver. Each beat is offered after a random wait, and valid
   // stays up with a steady payload until the block takes it.
   int unsigned send_wait  = 0;
   int unsigned send_burst = 0;

   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_valid    <= 1'b0;
         enc_primed   = 1'b0;
         enc_phase    = '0;
         rotation     = 0;
         last_step_ms = '0;
         button_down  = 1'b0;
         press_ms     = '0;
         short_seen   = 1'b0;
         long_seen    = 1'b0;
         window_ms    = FAST_WINDOW_RESET;
         multiplier   = FAST_MULT_RESET;
         short_ms     = SHORT_LIMIT_RESET;
         long_ms      = LONG_LIMIT_RESET;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            pending_reports.push_back(advance_encoder(req_data));
            samples_taken++;
            offer = 1'b0;
         end
         if (!offer) begin
            if (send_wait != 0) begin
               send_wait--;
            end else if (sample_backlog.size() != 0) begin
               req_data  <= sample_backlog.pop_front();
               offer     = 1'b1;
               send_wait = draw_wait(send_burst);
            end
         end
         // Only one assignment to valid per edge, so a beat that follows
         // directly on an accepted one keeps valid high.
         req_valid <= offer;
      end
   end

   // Result monitor. Ready drops for a random wait after each beat. Twice in
   // the run it drops for a long stretch while the driver keeps offering,
   // which fills the pipeline and must pull req_ready low.
   int unsigned recv_wait  = 0;
   int unsigned recv_burst = 0;
   int unsigned choke_left = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               $display("%0t: result beat with nothing expected, got %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = pending_reports.pop_front();
               if (rsp_data.delta !== want.delta) begin
                  $display("%0t: delta expected %0d, actual %0d", $time,
                           $signed(want.delta), $signed(rsp_data.delta));
                  fail_count++;
               end
               if (rsp_data.short_click !== want.short_click) begin
                  $display("%0t: short_click expected %b, actual %b", $time,
                           want.short_click, rsp_data.short_click);
                  fail_count++;
               end
               if (rsp_data.long_click !== want.long_click) begin
                  $display("%0t: long_click expected %b, actual %b", $time,
                           want.long_click, rsp_data.long_click);
                  fail_count++;
               end
            end
            reports_seen++;
            recv_wait = draw_wait(recv_burst);
            if (reports_seen % 700 == 350) begin
               choke_left = 150;
            end
         end
         if (choke_left != 0) begin
            choke_left--;
            rsp_ready <= 1'b0;
         end else if (recv_wait != 0) begin
            recv_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: any beat on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
         $display("rotary_encoder_with_click_detect_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed opening, at the reset register values.
      // The first sample only primes the phase.
      queue_sample(1, 1, 1, 32'd0, 0, 0, 0);
      // Two quick steps are accelerated, since the last step time starts at
      // zero; a slow one is not, then a reversal inside the window.
      queue_sample(1, 0, 1, 32'd10, 0, 0, 0);
      queue_sample(0, 0, 1, 32'd20, 0, 0, 0);
      queue_sample(0, 1, 1, 32'd200, 0, 0, 0);
      queue_sample(0, 0, 1, 32'd210, 0, 0, 0);
      // A jump across two Gray positions is a glitch and adds nothing.
      queue_sample(1, 1, 1, 32'd220, 0, 0, 0);
      queue_sample(1, 1, 1, 32'd230, 1, 0, 0);
      // A short press and release, cleared by its take bit.
      queue_sample(1, 1, 0, 32'd300, 0, 0, 0);
      queue_sample(1, 1, 1, 32'd500, 0, 1, 0);
      // A hold just past the long limit flags, re-arms, and the quick
      // release of the new press then counts as a short click too.
      queue_sample(1, 1, 0, 32'd600, 0, 0, 0);
      queue_sample(1, 1, 0, 32'd2601, 0, 0, 0);
      queue_sample(1, 1, 0, 32'd2602, 0, 0, 0);
      queue_sample(1, 1, 1, 32'd2700, 0, 1, 1);
      // Release exactly at the short limit is not a short click.
      queue_sample(1, 1, 0, 32'd3000, 0, 0, 0);
      queue_sample(1, 1, 1, 32'd4200, 0, 0, 0);
      // A hold of exactly the long limit is not yet long; one more is.
      queue_sample(1, 1, 0, 32'd5000, 0, 0, 0);
      queue_sample(1, 1, 0, 32'd7000, 0, 0, 0);
      queue_sample(1, 1, 0, 32'd7001, 0, 0, 1);
      queue_sample(1, 1, 1, 32'd7002, 0, 0, 0);
      // A press that straddles the wrap of the millisecond clock.
      queue_sample(1, 1, 0, 32'hFFFF_FF00, 0, 0, 0);
      queue_sample(0, 1, 1, 32'h0000_0010, 1, 1, 1);
      queue_sample(0, 0, 1, 32'hFFFF_FFFF, 0, 0, 0);
      queue_sample(1, 0, 1, 32'hFFFF_FFFF, 1, 1, 1);
      stim_now = 32'hFFFF_FFFF;

      // Random batch at the reset register values.
      queue_random_samples(PHASE_SAMPLES);

      // Extremes first: the widest window at the largest factor with the longest
      // long limit, then nothing accelerated and no short clicks while any hold is
      // long, then a swallowing zero multiplier.
      run_phase(16'hFFFF, 4'd15, 16'hFFFF, 16'hFFFF);
      run_phase(16'd0, 4'd1, 16'd0, 16'd0);
      run_phase(16'd300, 4'd0, 16'd500, 16'd800);
      run_phase(16'd1, 4'd3, 16'd1, 16'd1);
      run_phase(16'd150, 4'd2, 16'd65535, 16'd1500);
      repeat (3) begin
         run_phase(16'($urandom_range(0, 400)), 4'($urandom_range(0, 15)),
                   16'($urandom_range(0, 3000)), 16'($urandom_range(0, 4000)));
      end

      wait_for_drain();
      if (fail_count == 0) begin
         $display("rotary_encoder_with_click_detect_tb OK");
      end else begin
         $display("rotary_encoder_with_click_detect_tb NOT OK");
      end
      $finish;
   end

endmodule

[rotary_encoder_with_click_detect.f]
hdl/rce_pkg.sv
hdl/rce_rotation.sv
hdl/rce_button.sv
hdl/rotary_encoder_with_click_detect.sv
tb/sv/rotary_encoder_with_click_detect_tb.sv
